@@ hw/rtl/scps_pkg.sv @@
// Package for the song chain pattern sequencer: sizes, entry format, action and state codes.
`timescale 1ns / 1ps
package scps_pkg;

  localparam int CHAIN_ENTRIES = 16;
  localparam int AW            = $clog2(CHAIN_ENTRIES);

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  // One chain entry as stored in the chain RAM
  typedef struct packed {
    logic       fin;
    logic [4:0] reps;
    logic [1:0] pat;
  } chain_entry_t;

  localparam int ENTRY_W = $bits(chain_entry_t);

  localparam chain_entry_t ENTRY_PLAY = '{fin: 1'b0, reps: 5'd1, pat: 2'd0};
  localparam chain_entry_t ENTRY_END  = '{fin: 1'b1, reps: 5'd1, pat: 2'd0};

  typedef enum logic [3:0] {
    ACT_BOUNDARY = 4'd0,
    ACT_SET      = 4'd1,
    ACT_INSERT   = 4'd2,
    ACT_DELETE   = 4'd3,
    ACT_START    = 4'd4,
    ACT_STOP     = 4'd5,
    ACT_PAUSE    = 4'd6,
    ACT_CONTINUE = 4'd7,
    ACT_QUEUE    = 4'd8,
    ACT_UNQUEUE  = 4'd9,
    ACT_DEFAULT  = 4'd10
  } action_e;

  typedef enum logic [1:0] {
    REG_LOOP_MODE  = 2'd0,
    REG_LOOP_FIRST = 2'd1,
    REG_LOOP_LAST  = 2'd2
  } cfg_reg_e;

  localparam logic [1:0] MODE_NO_LOOP = 2'd0;
  localparam logic [1:0] MODE_RANGE   = 2'd1;
  localparam logic [1:0] MODE_HOLD    = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_BND_CUR,
    ST_BND_NXT,
    ST_CONT,
    ST_START,
    ST_INS_RD,
    ST_INS_WR,
    ST_DEL_RD,
    ST_DEL_WR,
    ST_DEL_TAIL,
    ST_DEL_CHK,
    ST_DEL_FIX,
    ST_RES_RD,
    ST_RES
  } seq_state_e;

endpackage

@@ hw/rtl/scps_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
module scps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/song_chain_pattern_sequencer_core.sv @@
// Song chain pattern sequencer: chain RAM, transport state and the sequencer around them.
`timescale 1ns / 1ps
// The block keeps a chain of CHAIN_ENTRIES entries (pattern 0-3, repeat count 1-16, end
// marker) in a small RAM with one write and one registered read port, and a transport
// (playing, position, repeat index, one queued pattern) that walks it. Every request on the
// slave side gives exactly one result on the master side. All chain accesses go one at a
// time through the RAM ports under a small sequencer, so s_axis_tready is high only
// while the sequencer is idle. Set, stop, pause, queue, unqueue, unused codes and a
// boundary taken while stopped or with a pattern queued go from ST_EXEC straight to the
// result read; start, continue and a boundary that stays on its entry or runs off the
// chain read one entry first; a boundary that reaches the next entry reads two; insert and
// delete move one entry per read and write pair; the default song rewrites the whole chain.
// After reset a clearing pass over all CHAIN_ENTRIES entries loads the default song while
// no request is taken; configuration writes are taken at any time but are only meant to
// land while the block is idle. A finished result sits in an output register, so the next
// request is taken while it waits for m_axis_tready. Loop registers are sanitised on use:
// mode 3 acts as no loop, a loop end below the loop start acts as the start.
module song_chain_pattern_sequencer_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write port
  input  logic                             cfg_we_i,
  input  logic [1:0]                       cfg_index_i,
  input  logic [3:0]                       cfg_wdata_i,
  // Event requests
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // action[3:0], entry_index[7:4], pattern_number[9:8], repeat_request[17:10],
  // end_marker[18], zero fill [23:19]
  input  logic [scps_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // Results
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // next_valid[0], next_pattern[2:1], playing[3], song_position[7:4],
  // current_pattern[9:8], repeat_target[14:10], repeats_done[18:15],
  // queue_pending[19], zero fill [23:20]
  output logic [scps_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  import scps_pkg::*;

  seq_state_e state_q, state_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic          clr_resume_q, clr_resume_d;

  // latched request
  logic [3:0] act_q;
  logic [3:0] idx_q;
  logic [1:0] pat_q;
  logic [7:0] req_q;
  logic       fin_q;

  // transport
  logic       playing_q, playing_d;
  logic [3:0] pos_q, pos_d;
  logic [3:0] rep_q, rep_d;
  logic       qflag_q, qflag_d;
  logic [1:0] qpat_q, qpat_d;
  logic [3:0] npos_q, npos_d;

  // result of the boundary decision
  logic       nvalid_q, nvalid_d;
  logic [1:0] npat_q, npat_d;

  // loop registers
  logic [1:0] mode_q;
  logic [3:0] first_q, last_q;
  logic       loop_reset;

  // output register
  logic                   out_valid_q, out_valid_d;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;

  // chain RAM
  logic         ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  chain_entry_t ram_wdata, ram_rdata;
  logic [ENTRY_W-1:0] ram_rdata_raw;

  scps_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CHAIN_ENTRIES)
  ) u_chain_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = chain_entry_t'(ram_rdata_raw);

  // sanitised loop settings
  logic [1:0] mode_eff;
  logic [3:0] first_eff, last_cap, last_eff;
  logic [4:0] rep_inc;
  logic [4:0] npos_calc;
  logic       in_range;
  logic [4:0] reps_sat;
  chain_entry_t set_entry;

  always_comb begin
    mode_eff  = (mode_q == MODE_HOLD || mode_q == MODE_RANGE) ? mode_q : MODE_NO_LOOP;
    first_eff = (int'(first_q) >= CHAIN_ENTRIES) ? 4'd0 : first_q;
    last_cap  = (int'(last_q) >= CHAIN_ENTRIES) ? 4'(CHAIN_ENTRIES - 1) : last_q;
    last_eff  = (last_cap < first_eff) ? first_eff : last_cap;
    rep_inc   = {1'b0, rep_q} + 5'd1;
    npos_calc = (mode_eff == MODE_RANGE && pos_q >= last_eff) ? {1'b0, first_eff}
                                                              : {1'b0, pos_q} + 5'd1;
    in_range  = int'(idx_q) < CHAIN_ENTRIES;
    if (req_q == 8'd0) begin
      reps_sat = 5'd1;
    end else if (req_q > 8'd16) begin
      reps_sat = 5'd16;
    end else begin
      reps_sat = req_q[4:0];
    end
    set_entry = '{fin: fin_q, reps: reps_sat, pat: pat_q};
  end

  assign s_axis_tready  = (state_q == ST_IDLE);
  assign m_axis_tvalid  = out_valid_q;
  assign m_axis_tdata   = out_data_q;

  // sequencer: next state, transport and RAM control
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    clr_resume_d = clr_resume_q;
    playing_d    = playing_q;
    pos_d        = pos_q;
    rep_d        = rep_q;
    qflag_d      = qflag_q;
    qpat_d       = qpat_q;
    npos_d       = npos_q;
    nvalid_d     = nvalid_q;
    npat_d       = npat_q;
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    loop_reset   = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = cnt_q;
    ram_wdata    = ENTRY_END;
    ram_raddr    = AW'(pos_q);

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = (cnt_q == '0) ? ENTRY_PLAY : ENTRY_END;
        cnt_d     = cnt_q + AW'(1);
        if (int'(cnt_q) == CHAIN_ENTRIES - 1) begin
          state_d = clr_resume_q ? ST_RES_RD : ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d  = ST_EXEC;
          nvalid_d = 1'b0;
          npat_d   = 2'd0;
        end
      end

      ST_EXEC: begin
        state_d = ST_RES_RD;
        case (action_e'(act_q))
          ACT_BOUNDARY: begin
            if (playing_q && qflag_q) begin
              nvalid_d = 1'b1;
              npat_d   = qpat_q;
              qflag_d  = 1'b0;
              rep_d    = 4'd0;
            end else if (playing_q) begin
              ram_raddr = AW'(pos_q);
              state_d   = ST_BND_CUR;
            end
          end
          ACT_SET: begin
            if (in_range) begin
              ram_we    = 1'b1;
              ram_waddr = AW'(idx_q);
              ram_wdata = set_entry;
            end
          end
          ACT_INSERT: begin
            if (in_range) begin
              cnt_d   = AW'(CHAIN_ENTRIES - 1);
              state_d = ST_INS_RD;
            end
          end
          ACT_DELETE: begin
            if (in_range) begin
              cnt_d   = AW'(idx_q);
              state_d = ST_DEL_RD;
            end
          end
          ACT_START: begin
            playing_d = 1'b0;
            pos_d     = 4'd0;
            rep_d     = 4'd0;
            qflag_d   = 1'b0;
            qpat_d    = 2'd0;
            ram_raddr = '0;
            state_d   = ST_START;
          end
          ACT_STOP: begin
            playing_d = 1'b0;
            pos_d     = 4'd0;
            rep_d     = 4'd0;
            qflag_d   = 1'b0;
            qpat_d    = 2'd0;
          end
          ACT_PAUSE: begin
            playing_d = 1'b0;
          end
          ACT_CONTINUE: begin
            ram_raddr = AW'(pos_q);
            state_d   = ST_CONT;
          end
          ACT_QUEUE: begin
            qflag_d = 1'b1;
            qpat_d  = pat_q;
          end
          ACT_UNQUEUE: begin
            qflag_d = 1'b0;
          end
          ACT_DEFAULT: begin
            loop_reset   = 1'b1;
            playing_d    = 1'b0;
            pos_d        = 4'd0;
            rep_d        = 4'd0;
            qflag_d      = 1'b0;
            qpat_d       = 2'd0;
            cnt_d        = '0;
            clr_resume_d = 1'b1;
            state_d      = ST_CLEAR;
          end
          default: begin
          end
        endcase
      end

      // current entry available
      ST_BND_CUR: begin
        state_d = ST_RES_RD;
        if (mode_eff == MODE_HOLD) begin
          nvalid_d = 1'b1;
          npat_d   = ram_rdata.pat;
        end else if (rep_inc < ram_rdata.reps) begin
          rep_d    = rep_inc[3:0];
          nvalid_d = 1'b1;
          npat_d   = ram_rdata.pat;
        end else begin
          rep_d = 4'd0;
          if (int'(npos_calc) >= CHAIN_ENTRIES) begin
            playing_d = 1'b0;
            pos_d     = 4'd0;
            qflag_d   = 1'b0;
            qpat_d    = 2'd0;
          end else begin
            npos_d    = npos_calc[3:0];
            ram_raddr = AW'(npos_calc);
            state_d   = ST_BND_NXT;
          end
        end
      end

      // entry at the new position available
      ST_BND_NXT: begin
        state_d = ST_RES_RD;
        if (ram_rdata.fin) begin
          playing_d = 1'b0;
          pos_d     = 4'd0;
          rep_d     = 4'd0;
          qflag_d   = 1'b0;
          qpat_d    = 2'd0;
        end else begin
          pos_d    = npos_q;
          nvalid_d = 1'b1;
          npat_d   = ram_rdata.pat;
        end
      end

      ST_CONT: begin
        if (!playing_q && !ram_rdata.fin) begin
          playing_d = 1'b1;
        end
        state_d = ST_RES_RD;
      end

      ST_START: begin
        playing_d = !ram_rdata.fin;
        state_d   = ST_RES_RD;
      end

      // insert: move entries up from the top, one read and one write each
      ST_INS_RD: begin
        if (cnt_q > AW'(idx_q)) begin
          ram_raddr = cnt_q - AW'(1);
          state_d   = ST_INS_WR;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = AW'(idx_q);
          ram_wdata = ENTRY_PLAY;
          state_d   = ST_RES_RD;
        end
      end

      ST_INS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = ram_rdata;
        cnt_d     = cnt_q - AW'(1);
        state_d   = ST_INS_RD;
      end

      // delete: move entries down from the index
      ST_DEL_RD: begin
        if (int'(cnt_q) + 1 < CHAIN_ENTRIES) begin
          ram_raddr = cnt_q + AW'(1);
          state_d   = ST_DEL_WR;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = AW'(CHAIN_ENTRIES - 1);
          ram_wdata = ENTRY_END;
          state_d   = ST_DEL_TAIL;
        end
      end

      ST_DEL_WR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = ram_rdata;
        cnt_d     = cnt_q + AW'(1);
        state_d   = ST_DEL_RD;
      end

      ST_DEL_TAIL: begin
        ram_raddr = '0;
        state_d   = ST_DEL_CHK;
      end

      // keep entry 0 playable
      ST_DEL_CHK: begin
        if (ram_rdata.fin) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          ram_wdata = ENTRY_PLAY;
          state_d   = ST_DEL_FIX;
        end else begin
          state_d = ST_RES_RD;
        end
      end

      ST_DEL_FIX: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(1);
        ram_wdata = ENTRY_END;
        state_d   = ST_RES_RD;
      end

      ST_RES_RD: begin
        ram_raddr = AW'(pos_q);
        state_d   = ST_RES;
      end

      // hold the read address until the output register is free
      ST_RES: begin
        ram_raddr = AW'(pos_q);
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = '0;
          out_data_d[0]     = nvalid_q;
          out_data_d[2:1]   = nvalid_q ? npat_q : 2'd0;
          out_data_d[3]     = playing_q;
          out_data_d[7:4]   = pos_q;
          out_data_d[9:8]   = ram_rdata.fin ? 2'd0 : ram_rdata.pat;
          out_data_d[14:10] = ram_rdata.fin ? 5'd1 : ram_rdata.reps;
          out_data_d[18:15] = rep_q;
          out_data_d[19]    = qflag_q;
          state_d           = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      cnt_q        <= '0;
      clr_resume_q <= 1'b0;
      playing_q    <= 1'b0;
      pos_q        <= 4'd0;
      rep_q        <= 4'd0;
      qflag_q      <= 1'b0;
      qpat_q       <= 2'd0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      clr_resume_q <= (state_q == ST_CLEAR && state_d != ST_CLEAR) ? 1'b0 : clr_resume_d;
      playing_q    <= playing_d;
      pos_q        <= pos_d;
      rep_q        <= rep_d;
      qflag_q      <= qflag_d;
      qpat_q       <= qpat_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // loop registers: config writes, or back to reset values on the default song
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_RANGE;
      first_q <= 4'd0;
      last_q  <= 4'd0;
    end else if (loop_reset) begin
      mode_q  <= MODE_RANGE;
      first_q <= 4'd0;
      last_q  <= 4'd0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_LOOP_MODE:  mode_q  <= cfg_wdata_i[1:0];
        REG_LOOP_FIRST: first_q <= cfg_wdata_i;
        REG_LOOP_LAST:  last_q  <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && s_axis_tvalid) begin
      act_q <= s_axis_tdata[3:0];
      idx_q <= s_axis_tdata[7:4];
      pat_q <= s_axis_tdata[9:8];
      req_q <= s_axis_tdata[17:10];
      fin_q <= s_axis_tdata[18];
    end
    npos_q     <= npos_d;
    nvalid_q   <= nvalid_d;
    npat_q     <= npat_d;
    out_data_q <= out_data_d;
  end

endmodule

@@ hw/rtl/scps_checker.sv @@
// Port-level checks for the song chain pattern sequencer, bound to the top level.
`timescale 1ns / 1ps
module scps_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [scps_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  import scps_pkg::*;

  // a stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result payload changed while stalled");

  // a next pattern is only offered by a running transport
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[3])
    else $error("next pattern offered while stopped");

  // next pattern reads zero when none is offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[2:1] == 2'd0)
    else $error("next pattern not zero without next_valid");

  // repeat target stays within 1..16
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[14:10] != 5'd0 && m_axis_tdata[14:10] <= 5'd16)
    else $error("repeat target out of range");

  // one request at a time: busy straight after acceptance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");

endmodule

bind song_chain_pattern_sequencer_core scps_checker u_scps_checker (.*);
